// ===== design/bracket_nesting_checker_defines.svh =====
// Assertion macros for the checker file bnc_checker.sv.
`ifndef BRACKET_NESTING_CHECKER_DEFINES_SVH
`define BRACKET_NESTING_CHECKER_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define BNC_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define BNC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/bnc_pkg.sv =====
`default_nettype none
package bnc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int PAIR_COUNT_DEF  = 4;
  localparam int LINE_WIDTH_DEF  = 16;

  localparam int PAIR_IDX_W   = 2;
  localparam int ERR_LINE_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [31:0] OPEN_SET_RESET  = 32'h007B5B28;
  localparam logic [31:0] CLOSE_SET_RESET = 32'h007D5D29;
  localparam logic [7:0]  NEWLINE_CHAR    = 8'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OPEN_SET  = 1'b0,
    CFG_CLOSE_SET = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_NOT_OPEN = 3'd1,
    VERDICT_MISMATCH = 3'd2,
    VERDICT_UNCLOSED = 3'd3,
    VERDICT_OVERFLOW = 3'd4
  } verdict_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic                  newline;
    logic                  is_open;
    logic                  is_close;
    logic [PAIR_IDX_W-1:0] pair;
    logic                  last;
  } item_t;

endpackage
`default_nettype wire

// ===== design/bnc_front.sv =====
`default_nettype none
module bnc_front #(
  parameter int PAIR_COUNT = bnc_pkg::PAIR_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bnc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic [7:0]                       text_char,
  input  wire logic                             last,
  output bnc_pkg::item_t                        item
);

  logic [31:0] open_set;
  logic [31:0] close_set;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_set  <= bnc_pkg::OPEN_SET_RESET;
      close_set <= bnc_pkg::CLOSE_SET_RESET;
    end else if (cfg_valid) begin
      case (bnc_pkg::cfg_reg_t'(cfg_index))
        bnc_pkg::CFG_OPEN_SET:  open_set  <= cfg_data;
        bnc_pkg::CFG_CLOSE_SET: close_set <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan from the top pair down so the lowest matching index wins.
  always_comb begin
    logic [bnc_pkg::PAIR_IDX_W-1:0] open_idx;
    logic [bnc_pkg::PAIR_IDX_W-1:0] close_idx;
    logic                           open_hit;
    logic                           close_hit;
    open_idx  = '0;
    close_idx = '0;
    open_hit  = 1'b0;
    close_hit = 1'b0;
    for (int i = PAIR_COUNT - 1; i >= 0; i--) begin
      if (open_set[8*i +: 8] != 8'd0 && open_set[8*i +: 8] == text_char) begin
        open_hit = 1'b1;
        open_idx = bnc_pkg::PAIR_IDX_W'(i);
      end
      if (close_set[8*i +: 8] != 8'd0 && close_set[8*i +: 8] == text_char) begin
        close_hit = 1'b1;
        close_idx = bnc_pkg::PAIR_IDX_W'(i);
      end
    end
    item.newline  = (text_char == bnc_pkg::NEWLINE_CHAR);
    item.is_open  = open_hit;
    item.is_close = close_hit && !open_hit;
    item.pair     = open_hit ? open_idx : close_idx;
    item.last     = last;
  end

endmodule
`default_nettype wire

// ===== design/bnc_queue.sv =====
`default_nettype none
module bnc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bnc_pkg::item_t  push_item,
  output logic                 full,
  output logic                 pop_valid,
  output bnc_pkg::item_t       pop_item,
  input  wire logic            pop
);

  localparam int PW = $clog2(bnc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bnc_pkg::QUEUE_DEPTH + 1);

  bnc_pkg::item_t entries [bnc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(bnc_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[head];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + PW'(1);
      end
      if (do_pop) begin
        head <= head + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/bnc_back.sv =====
`default_nettype none
module bnc_back #(
  parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF,
  parameter int LINE_WIDTH  = bnc_pkg::LINE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  input  wire bnc_pkg::item_t                 item,
  output logic                                take,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [2:0]                          verdict,
  output logic [bnc_pkg::ERR_LINE_W-1:0]      error_line
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  // The top entry lives in a register; the memory holds the entries below it.
  logic [bnc_pkg::PAIR_IDX_W-1:0] mem [STACK_DEPTH];
  logic [bnc_pkg::PAIR_IDX_W-1:0] rd_data;
  logic                           byp;
  logic [bnc_pkg::PAIR_IDX_W-1:0] byp_data;
  logic [bnc_pkg::PAIR_IDX_W-1:0] below;

  logic [LW-1:0]                  level;
  logic [LW-1:0]                  level_next;
  logic [bnc_pkg::PAIR_IDX_W-1:0] top;
  logic [bnc_pkg::PAIR_IDX_W-1:0] top_next;
  logic [LINE_WIDTH-1:0]          line_count;
  logic [LINE_WIDTH-1:0]          line_count_next;
  bnc_pkg::verdict_t              err;
  bnc_pkg::verdict_t              err_next;
  logic [LINE_WIDTH-1:0]          err_line;
  logic [LINE_WIDTH-1:0]          err_line_next;
  logic                           push;
  logic                           pop;
  bnc_pkg::verdict_t              res_verdict;
  logic [bnc_pkg::ERR_LINE_W-1:0] res_line;
  logic [AW-1:0]                  rd_addr;

  assign below = byp ? byp_data : rd_data;
  assign take  = item_valid && (!item.last || !result_valid || !result_stall);

  always_comb begin
    logic [LINE_WIDTH-1:0] line_upd;
    logic [LW-1:0]         level_upd;
    logic [LINE_WIDTH-1:0] src_line;
    logic [31:0]           wide_line;
    line_upd      = line_count;
    err_next      = err;
    err_line_next = err_line;
    push          = 1'b0;
    pop           = 1'b0;
    if (err == bnc_pkg::VERDICT_OK) begin
      if (item.newline && line_count != {LINE_WIDTH{1'b1}}) begin
        line_upd = line_count + LINE_WIDTH'(1);
      end
      if (item.is_open) begin
        if (level == LW'(STACK_DEPTH)) begin
          err_next      = bnc_pkg::VERDICT_OVERFLOW;
          err_line_next = line_upd;
        end else begin
          push = 1'b1;
        end
      end else if (item.is_close) begin
        if (level == '0) begin
          err_next      = bnc_pkg::VERDICT_NOT_OPEN;
          err_line_next = line_upd;
        end else if (top == item.pair) begin
          pop = 1'b1;
        end else begin
          err_next      = bnc_pkg::VERDICT_MISMATCH;
          err_line_next = line_upd;
        end
      end
    end
    level_upd = push ? level + LW'(1) : (pop ? level - LW'(1) : level);

    // Verdict as seen after this character.
    if (err_next != bnc_pkg::VERDICT_OK) begin
      res_verdict = err_next;
      src_line    = err_line_next;
    end else if (level_upd != '0) begin
      res_verdict = bnc_pkg::VERDICT_UNCLOSED;
      src_line    = line_upd;
    end else begin
      res_verdict = bnc_pkg::VERDICT_OK;
      src_line    = '0;
    end
    wide_line = 32'(src_line);
    res_line  = (wide_line > 32'h0000FFFF) ? {bnc_pkg::ERR_LINE_W{1'b1}}
                                           : wide_line[bnc_pkg::ERR_LINE_W-1:0];

    top_next        = push ? item.pair : (pop ? below : top);
    level_next      = level_upd;
    line_count_next = line_upd;
    if (item.last) begin
      level_next      = '0;
      line_count_next = '0;
      err_next        = bnc_pkg::VERDICT_OK;
      err_line_next   = '0;
    end
    if (!take) begin
      level_next      = level;
      top_next        = top;
      line_count_next = line_count;
      err_next        = err;
      err_line_next   = err_line;
    end
    rd_addr = AW'(level_next - LW'(2));
  end

  // Spill the old top on a push; prefetch the entry under the next top.
  always_ff @(posedge clk) begin
    if (take && push && level != '0) begin
      mem[AW'(level - LW'(1))] <= top;
    end
    rd_data  <= mem[rd_addr];
    byp_data <= top;
    top      <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      line_count   <= '0;
      err          <= bnc_pkg::VERDICT_OK;
      err_line     <= '0;
      byp          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      level      <= level_next;
      line_count <= line_count_next;
      err        <= err_next;
      err_line   <= err_line_next;
      byp        <= take && push;
      if (take && item.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      verdict    <= res_verdict;
      error_line <= res_line;
    end
  end

endmodule
`default_nettype wire

// ===== design/bracket_nesting_checker.sv =====
// Bracket nesting checker.
// Text channel: text_valid/text_stall carry one character (text_char) per beat;
// last marks the final character of a stream. Result channel: result_valid /
// result_stall carry one beat per stream, verdict and error_line, produced for
// the beat marked last only. Config channel: cfg_valid/cfg_ready with cfg_index
// 0 for the open set and 1 for the close set; cfg_ready is always high. Write
// configuration only while no stream is in flight.
// Throughput: one character per cycle while text_stall is low, set by the stack
// top update in the back end (top of stack in a register, next entry
// prefetched from the stack memory). The result is registered onto
// result_valid after the last character passes the queue and is taken.
// Reset (rst, synchronous): configuration returns to ( [ { and ) ] }, the stack,
// line counter and error latch clear, and no result is pending. The stack
// memory itself is not cleared; only entries below the current level are read.
// When result_stall holds a result, characters keep flowing until the next
// last beat reaches the back end; the two-entry queue then fills and
// text_stall rises.
`default_nettype none
module bracket_nesting_checker #(
  parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF,
  parameter int PAIR_COUNT  = bnc_pkg::PAIR_COUNT_DEF,
  parameter int LINE_WIDTH  = bnc_pkg::LINE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bnc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic                             text_valid,
  output logic                                  text_stall,
  input  wire logic [7:0]                       text_char,
  input  wire logic                             last,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [2:0]                            verdict,
  output logic [bnc_pkg::ERR_LINE_W-1:0]        error_line
);

  bnc_pkg::item_t front_item;
  bnc_pkg::item_t back_item;
  logic           q_full;
  logic           q_valid;
  logic           q_take;

  assign text_stall = q_full;

  bnc_front #(
    .PAIR_COUNT(PAIR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text_char (text_char),
    .last      (last),
    .item      (front_item)
  );

  bnc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (text_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (back_item),
    .pop       (q_take)
  );

  bnc_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (q_valid),
    .item         (back_item),
    .take         (q_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .error_line   (error_line)
  );

endmodule
`default_nettype wire

// ===== design/bnc_checker.sv =====
`default_nettype none
`include "bracket_nesting_checker_defines.svh"
module bnc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             text_stall,
  input wire logic                             result_valid,
  input wire logic                             result_stall,
  input wire logic [2:0]                       verdict,
  input wire logic [bnc_pkg::ERR_LINE_W-1:0]   error_line
);

  `BNC_ASSERT_NOW(a_ok_no_line, result_valid && verdict == bnc_pkg::VERDICT_OK, error_line == '0, "ok verdict with nonzero line")
  `BNC_ASSERT_NOW(a_idle_after_reset, $past(rst), !result_valid && !text_stall, "busy right after reset")
  `BNC_ASSERT_NOW(a_verdict_code, result_valid, verdict <= bnc_pkg::VERDICT_OVERFLOW, "verdict code out of range")
  `BNC_ASSERT_NEXT(a_hold_stalled, result_valid && result_stall, result_valid && $stable(verdict) && $stable(error_line), "stalled result changed")

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (
  .clk          (clk),
  .rst          (rst),
  .text_stall   (text_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .verdict      (verdict),
  .error_line   (error_line)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_GAP    = 8;
  localparam int BLOCK_BEATS = 100;
  localparam int PRINT_CAP   = 50;

  localparam logic [7:0] C_LPAR = 8'h28;
  localparam logic [7:0] C_RPAR = 8'h29;
  localparam logic [7:0] C_LBRK = 8'h5B;
  localparam logic [7:0] C_RBRK = 8'h5D;
  localparam logic [7:0] C_LBRC = 8'h7B;
  localparam logic [7:0] C_RBRC = 8'h7D;
  localparam logic [7:0] C_LT   = 8'h3C;
  localparam logic [7:0] C_GT   = 8'h3E;

  typedef struct packed {
    bnc_pkg::verdict_t code;
    logic [15:0]       line;
  } verdict_exp_t;

  // One row is either a bracket-set write or a run of identical text beats.
  typedef struct {
    bit                wr;
    logic [31:0]       open_v;
    logic [31:0]       close_v;
    logic [7:0]        ch;
    int                reps;
    bit                lst;
    bit                typed;
    bnc_pkg::verdict_t code;
    logic [15:0]       line;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        text_valid;
  logic        text_stall;
  logic [7:0]  text_char;
  logic        last;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  verdict;
  logic [15:0] error_line;

  bracket_nesting_checker dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_char    (text_char),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .error_line   (error_line)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Nesting predictor state
  logic [31:0]       open_bytes  = bnc_pkg::OPEN_SET_RESET;
  logic [31:0]       close_bytes = bnc_pkg::CLOSE_SET_RESET;
  logic [1:0]        nest_stack [bnc_pkg::STACK_DEPTH_DEF];
  int unsigned       nest_level  = 0;
  logic [15:0]       line_cnt    = '0;
  bnc_pkg::verdict_t err_code    = bnc_pkg::VERDICT_OK;
  logic [15:0]       err_line    = '0;

  verdict_exp_t pending_verdicts [$];
  bit           typed_on;
  verdict_exp_t typed_exp;

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int cycles;
  int beats_total;
  int streams_total;
  int sets_total;
  int verdict_seen [5];
  logic [7:0] stream_q [$];
  plan_row_t  plan [23];

  function automatic int pair_index(input logic [31:0] set, input logic [7:0] c);
    for (int i = 0; i < bnc_pkg::PAIR_COUNT_DEF; i++) begin
      if (set[8*i +: 8] != 8'h00 && set[8*i +: 8] == c) return i;
    end
    return -1;
  endfunction

  // Advance the nesting state by one beat; returns 1 when a verdict is due.
  function automatic bit predict_beat(input logic [7:0] c, input logic lst,
                                      output bnc_pkg::verdict_t code,
                                      output logic [15:0] line);
    int oi;
    int ci;
    if (err_code == bnc_pkg::VERDICT_OK) begin
      if (c == bnc_pkg::NEWLINE_CHAR && line_cnt != 16'hFFFF) line_cnt++;
      oi = pair_index(open_bytes, c);
      ci = pair_index(close_bytes, c);
      if (oi >= 0) begin
        if (nest_level >= bnc_pkg::STACK_DEPTH_DEF) begin
          err_code = bnc_pkg::VERDICT_OVERFLOW;
          err_line = line_cnt;
        end else begin
          nest_stack[nest_level] = 2'(oi);
          nest_level++;
        end
      end else if (ci >= 0) begin
        if (nest_level == 0) begin
          err_code = bnc_pkg::VERDICT_NOT_OPEN;
          err_line = line_cnt;
        end else if (nest_stack[nest_level-1] == 2'(ci)) begin
          nest_level--;
        end else begin
          err_code = bnc_pkg::VERDICT_MISMATCH;
          err_line = line_cnt;
        end
      end
    end
    code = bnc_pkg::VERDICT_OK;
    line = '0;
    if (!lst) return 1'b0;
    if (err_code != bnc_pkg::VERDICT_OK) begin
      code = err_code;
      line = err_line;
    end else if (nest_level > 0) begin
      code = bnc_pkg::VERDICT_UNCLOSED;
      line = line_cnt;
    end
    nest_level = 0;
    line_cnt   = '0;
    err_code   = bnc_pkg::VERDICT_OK;
    err_line   = '0;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("error @ cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycles, pending_verdicts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check result beats first, then fold in config and text beats of this edge.
  always @(posedge clk) begin
    verdict_exp_t      want;
    bnc_pkg::verdict_t pv;
    logic [15:0]       pl;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_verdicts.size() == 0) begin
          report($sformatf("unexpected verdict %0d line %0d", verdict, error_line));
        end else begin
          want = pending_verdicts.pop_front();
          verdict_seen[int'(want.code)]++;
          if (verdict !== want.code || error_line !== want.line)
            report($sformatf("verdict %0d line %0d, want %0d line %0d",
                             verdict, error_line, want.code, want.line));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (bnc_pkg::cfg_reg_t'(cfg_index))
          bnc_pkg::CFG_OPEN_SET:  open_bytes  = cfg_data;
          bnc_pkg::CFG_CLOSE_SET: close_bytes = cfg_data;
          default: ;
        endcase
      end
      if (text_valid && !text_stall) begin
        if (predict_beat(text_char, last, pv, pl)) begin
          if (typed_on) want = typed_exp;
          else want = '{code: pv, line: pl};
          pending_verdicts = {pending_verdicts, want};
        end
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_beat(input logic [7:0] c, input logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    text_valid <= 1'b1;
    text_char  <= c;
    last       <= lst;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    @(negedge clk);
    beats_total++;
  endtask

  // Drop valid, let every verdict drain, then give the pipeline time to settle.
  task automatic wait_idle();
    text_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input bnc_pkg::cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_brackets(input logic [31:0] open_v, input logic [31:0] close_v);
    wait_idle();
    write_reg(bnc_pkg::CFG_OPEN_SET, open_v);
    write_reg(bnc_pkg::CFG_CLOSE_SET, close_v);
    cfg_valid <= 1'b0;
    sets_total++;
  endtask

  function automatic bit pair_usable(input int p);
    logic [7:0] o;
    logic [7:0] c;
    o = open_bytes[8*p +: 8];
    c = close_bytes[8*p +: 8];
    return o != 8'h00 && c != 8'h00 && pair_index(open_bytes, o) == p &&
           pair_index(close_bytes, c) == p && pair_index(open_bytes, c) < 0;
  endfunction

  // Plain text: neither bracket byte, newline about one time in six.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    if ($urandom_range(5) == 0 && pair_index(open_bytes, bnc_pkg::NEWLINE_CHAR) < 0 &&
        pair_index(close_bytes, bnc_pkg::NEWLINE_CHAR) < 0)
      return bnc_pkg::NEWLINE_CHAR;
    do b = 8'($urandom_range(255));
    while (pair_index(open_bytes, b) >= 0 || pair_index(close_bytes, b) >= 0);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [31:0] set;
    logic [7:0]  b;
    if ($urandom_range(1) == 0) begin
      set = $urandom_range(1) ? open_bytes : close_bytes;
      b = set[8*$urandom_range(3) +: 8];
      if (b != 8'h00) return b;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic make_stream();
    int kind;
    int n;
    int p;
    int open_stk [$];
    int usable [$];
    stream_q.delete();
    for (int i = 0; i < bnc_pkg::PAIR_COUNT_DEF; i++) if (pair_usable(i)) usable = {usable, i};
    kind = $urandom_range(99);
    if (usable.size() == 0 || kind >= 80) begin
      n = $urandom_range(1, 20);
      repeat (n) stream_q = {stream_q, noise_byte()};
    end else if (kind >= 75) begin
      // deep nest: about half of these run past the stack
      n = $urandom_range(58, 70);
      repeat (n) begin
        p = usable[$urandom_range(usable.size()-1)];
        open_stk = {open_stk, p};
        stream_q = {stream_q, open_bytes[8*p +: 8]};
      end
      while (open_stk.size() != 0) begin
        p = open_stk[$];
        open_stk.delete(open_stk.size() - 1);
        stream_q = {stream_q, close_bytes[8*p +: 8]};
      end
    end else begin
      n = $urandom_range(0, 30);
      repeat (n) begin
        case ($urandom_range(2))
          0: begin
            if (open_stk.size() < bnc_pkg::STACK_DEPTH_DEF) begin
              p = usable[$urandom_range(usable.size()-1)];
              open_stk = {open_stk, p};
              stream_q = {stream_q, open_bytes[8*p +: 8]};
            end else stream_q = {stream_q, filler_byte()};
          end
          1: begin
            if (open_stk.size() != 0) begin
              p = open_stk[$];
              open_stk.delete(open_stk.size() - 1);
              stream_q = {stream_q, close_bytes[8*p +: 8]};
            end else stream_q = {stream_q, filler_byte()};
          end
          default: stream_q = {stream_q, filler_byte()};
        endcase
      end
      if ($urandom_range(9) != 0) begin
        while (open_stk.size() != 0) begin
          p = open_stk[$];
          open_stk.delete(open_stk.size() - 1);
          stream_q = {stream_q, close_bytes[8*p +: 8]};
        end
      end
      // broken: drop a stray noise byte, bracket or random, somewhere
      if (kind >= 60)
        stream_q.insert($urandom_range(stream_q.size()), noise_byte());
    end
    if (stream_q.size() == 0) stream_q = {stream_q, filler_byte()};
  endtask

  task automatic send_stream();
    typed_on = 1'b0;
    foreach (stream_q[i]) send_beat(stream_q[i], i == stream_q.size() - 1);
    streams_total++;
  endtask

  initial begin
    logic [31:0] ov;
    logic [31:0] cv;
    int          k;
    int          blk_beats;

    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = bnc_pkg::CFG_OPEN_SET;
    cfg_data      = '0;
    text_valid    = 1'b0;
    text_char     = '0;
    last          = 1'b0;
    result_stall  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    typed_on      = 1'b0;
    typed_exp     = '0;

    plan = '{
      '{1'b0, '0, '0, C_RPAR, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_NOT_OPEN, 16'd0},
      '{1'b0, '0, '0, C_LPAR, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_UNCLOSED, 16'd0},
      // newline before the failing close counts
      '{1'b0, '0, '0, C_LPAR, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, bnc_pkg::NEWLINE_CHAR, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_RBRK, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_MISMATCH, 16'd1},
      '{1'b0, '0, '0, C_LBRK, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_LBRC, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_RBRC, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_RBRK, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_OK, 16'd0},
      // zero and all-ones bytes never match the reset sets
      '{1'b0, '0, '0, 8'h00, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, 8'hFF, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_OK, 16'd0},
      // everything after the first error is ignored, newlines too
      '{1'b0, '0, '0, C_RPAR, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, bnc_pkg::NEWLINE_CHAR, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_LPAR, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_NOT_OPEN, 16'd0},
      '{1'b0, '0, '0, C_LPAR, 65, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_RPAR, 1, 1'b1, 1'b1, bnc_pkg::VERDICT_OVERFLOW, 16'd0},
      // newline opens pair 1, ')' closes pairs 0 and 1, '<' sits in both sets
      '{1'b1, 32'h003C0A28, 32'h3C3E2929, 8'h00, 0, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, bnc_pkg::NEWLINE_CHAR, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_RPAR, 1, 1'b1, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_LT, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_LT, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_GT, 1, 1'b0, 1'b0, bnc_pkg::VERDICT_OK, 16'd0},
      '{1'b0, '0, '0, C_GT, 1, 1'b1, 1'b0, bnc_pkg::VERDICT_OK, 16'd0}
    };

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].wr) begin
        set_brackets(plan[r].open_v, plan[r].close_v);
      end else begin
        for (int j = 0; j < plan[r].reps; j++) begin
          typed_on  = plan[r].typed;
          typed_exp = '{code: plan[r].code, line: plan[r].line};
          send_beat(plan[r].ch, plan[r].lst && j == plan[r].reps - 1);
        end
        if (plan[r].lst) streams_total++;
      end
    end
    typed_on = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        k = ph * 3 + blk;
        case (k)
          0: begin ov = bnc_pkg::OPEN_SET_RESET; cv = bnc_pkg::CLOSE_SET_RESET; end
          1: begin ov = 32'hFFFFFFFF;   cv = 32'h00000000;    end
          4: begin ov = 32'h00000000;   cv = 32'hFFFFFFFF;    end
          7: begin ov = 32'h3C7B5B28;   cv = 32'h3E7D5D29;    end
          default: begin
            for (int b = 0; b < 4; b++) begin
              ov[8*b +: 8] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
              cv[8*b +: 8] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
            end
          end
        endcase
        set_brackets(ov, cv);
        blk_beats = 0;
        while (blk_beats < BLOCK_BEATS) begin
          make_stream();
          send_stream();
          blk_beats += stream_q.size();
        end
      end
    end

    wait_idle();
    if (pending_verdicts.size() != 0)
      report($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    $display("run: %0d text beats in %0d streams under %0d bracket sets, four pacing mixes",
             beats_total, streams_total, sets_total);
    $display("verdicts: ok %0d, close w/o open %0d, mismatch %0d, unclosed %0d, overflow %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
